// ===== rtl/sdrg_pkg.sv =====
// Shared types, constants and glyph tables for the score digit rectangle generator.
// Depends on nothing; used by the controller, the datapath and the top level.
package sdrg_pkg;

  // field widths of the configuration register, input and result transactions
  localparam int CFG_W    = 10;
  localparam int NUMBER_W = 17;
  localparam int AX_W     = 15;
  localparam int AY_W     = 15;
  localparam int RX_W     = 18;
  localparam int RY_W     = 16;
  localparam int RW_W     = 14;
  localparam int RH_W     = 14;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;

  localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd32;

  localparam int DEF_MAX_DIGITS = 5;
  localparam int DEF_FRAC_BITS  = 4;

  // rectangle budget per transaction
  localparam int RECT_LIMIT = 25;
  localparam int RECT_CNT_W = 5;

  // glyph rows and counts
  localparam int ROW_W  = 3;
  localparam int DIGIT_W = 4;

  // distance table: index codes, scale factor width
  localparam int NUM_DIST = 5;
  localparam int DIDX_W   = 3;
  localparam int KSCALE_W = 9;
  localparam logic [DIDX_W-1:0] DIST_BAR    = 3'd0;
  localparam logic [DIDX_W-1:0] DIST_WIDTH  = 3'd1;
  localparam logic [DIDX_W-1:0] DIST_MID    = 3'd2;
  localparam logic [DIDX_W-1:0] DIST_BOTTOM = 3'd3;
  localparam logic [DIDX_W-1:0] DIST_ADV    = 3'd4;

  // floor(2^32 / 25), used after a shift by 4 to divide by 400
  localparam logic [31:0] RECIP_25 = 32'd171798691;
  // ceil(2^19 / 10), exact division by ten for 17-bit values
  localparam logic [15:0] RECIP_10 = 16'd52429;

  // point codes: bit 2 = right column, bits 1..0 = row
  localparam logic [2:0] PT_LT = 3'd0;
  localparam logic [2:0] PT_LM = 3'd1;
  localparam logic [2:0] PT_LB = 3'd2;
  localparam logic [2:0] PT_RT = 3'd4;
  localparam logic [2:0] PT_RM = 3'd5;
  localparam logic [2:0] PT_RB = 3'd6;
  localparam logic [5:0] PT_NONE = 6'd0;

  typedef enum logic [1:0] {
    S_CALC,
    S_IDLE,
    S_DIGIT,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              extract;
    logic              emit;
    logic              last;
    logic              next_digit;
    logic [ROW_W-1:0]  row;
    logic              calc_valid;
    logic [DIDX_W-1:0] calc_idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             num_zero;
    logic [ROW_W-1:0] glyph_cnt;
    logic             out_free;
  } dp_status_t;

  // scale factor k of each distance, D(k) = floor(h * 2^F * k / 400)
  function automatic logic [KSCALE_W-1:0] dist_k(input logic [DIDX_W-1:0] idx);
    logic [KSCALE_W-1:0] k;
    unique case (idx)
      DIST_BAR:    k = 9'd60;
      DIST_WIDTH:  k = 9'd160;
      DIST_MID:    k = 9'd153;
      DIST_BOTTOM: k = 9'd340;
      DIST_ADV:    k = 9'd220;
      default:     k = '0;
    endcase
    return k;
  endfunction

  // number of bars in a glyph
  function automatic logic [ROW_W-1:0] glyph_count(input logic [DIGIT_W-1:0] d);
    logic [ROW_W-1:0] c;
    unique case (d)
      4'd0:    c = 3'd4;
      4'd1:    c = 3'd1;
      4'd2:    c = 3'd5;
      4'd3:    c = 3'd4;
      4'd4:    c = 3'd4;
      4'd5:    c = 3'd5;
      4'd6:    c = 3'd4;
      4'd7:    c = 3'd2;
      4'd8:    c = 3'd5;
      4'd9:    c = 3'd4;
      default: c = 3'd1;
    endcase
    return c;
  endfunction

  // endpoint pair {a, b} of one bar; entry 0 in the lowest bits of the glyph word
  function automatic logic [5:0] glyph_pair(input logic [DIGIT_W-1:0] d,
                                            input logic [ROW_W-1:0] row);
    logic [4:0][5:0] w;
    logic [5:0]      p;
    unique case (d)
      4'd0: w = {PT_NONE, {PT_LT, PT_LB}, {PT_RB, PT_LB}, {PT_RT, PT_RB}, {PT_LT, PT_RT}};
      4'd1: w = {PT_NONE, PT_NONE, PT_NONE, PT_NONE, {PT_RT, PT_RB}};
      4'd2: w = {{PT_LB, PT_RB}, {PT_LM, PT_LB}, {PT_RM, PT_LM}, {PT_RT, PT_RM},
                 {PT_LT, PT_RT}};
      4'd3: w = {PT_NONE, {PT_LB, PT_RB}, {PT_LM, PT_RM}, {PT_LT, PT_RT}, {PT_RT, PT_RB}};
      4'd4: w = {PT_NONE, {PT_RM, PT_LM}, {PT_RT, PT_RM}, {PT_LT, PT_LM}, {PT_RT, PT_RB}};
      4'd5: w = {{PT_LB, PT_RB}, {PT_RM, PT_RB}, {PT_LM, PT_RM}, {PT_LT, PT_LM},
                 {PT_LT, PT_RT}};
      4'd6: w = {PT_NONE, {PT_RB, PT_LB}, {PT_RM, PT_RB}, {PT_LM, PT_RM}, {PT_LT, PT_LB}};
      4'd7: w = {PT_NONE, PT_NONE, PT_NONE, {PT_LT, PT_RT}, {PT_RT, PT_RB}};
      4'd8: w = {{PT_LM, PT_RM}, {PT_LB, PT_RB}, {PT_LT, PT_RT}, {PT_LT, PT_LB},
                 {PT_RT, PT_RB}};
      4'd9: w = {PT_NONE, {PT_LT, PT_RT}, {PT_LM, PT_LT}, {PT_LM, PT_RM}, {PT_RT, PT_RB}};
      default: w = '0;
    endcase
    unique case (row)
      3'd0:    p = w[0];
      3'd1:    p = w[1];
      3'd2:    p = w[2];
      3'd3:    p = w[3];
      3'd4:    p = w[4];
      default: p = PT_NONE;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/score_digit_rect_generator_core.sv =====
// Top level of the score digit rectangle generator: stream ports, controller
// and datapath. Depends on sdrg_pkg, sdrg_ctrl and sdrg_datapath.
//
// Each input transaction carries a number and a top-right anchor; the block
// returns one output transaction per glyph bar, least significant digit first,
// with tlast on the final rectangle. Each digit is first split off (multiply by
// the reciprocal of ten), then its bars are emitted, one bar per cycle while
// the output is not stalled. After reset and after every write of digit_height
// the distance table is recomputed through a three-stage multiply pipeline;
// the input is held off while it is recomputed.
module score_digit_rect_generator_core
  import sdrg_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration: digit_height
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // number[16:0], anchor_x[31:17], anchor_y[46:32]
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // rect_x[17:0], rect_y[33:18], rect_w[47:34],
                                             // rect_h[61:48]
  output logic                   out_tlast
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_accept;

  logic [RX_W-1:0] rect_x;
  logic [RY_W-1:0] rect_y;
  logic [RW_W-1:0] rect_w;
  logic [RH_W-1:0] rect_h;

  assign in_accept = in_tvalid && in_tready;

  // sequencing
  sdrg_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .in_accept (in_accept),
    .in_ready  (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  // arithmetic and result register
  sdrg_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_number   (in_tdata[16:0]),
    .in_anchor_x (in_tdata[31:17]),
    .in_anchor_y (in_tdata[46:32]),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_rect_x  (rect_x),
    .out_rect_y  (rect_y),
    .out_rect_w  (rect_w),
    .out_rect_h  (rect_h),
    .out_last    (out_tlast)
  );

  // pack result fields, zero fill to whole bytes
  assign out_tdata = {2'b00, rect_h, rect_w, rect_y, rect_x};

endmodule

// ===== rtl/sdrg_ctrl.sv =====
// Controller of the score digit rectangle generator: sequences distance
// calculation, digit extraction and rectangle emission. Depends on sdrg_pkg.
module sdrg_ctrl
  import sdrg_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       in_accept,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t st
);

  localparam int DIG_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CALC_CYCLES = NUM_DIST + 2;
  localparam logic [DIDX_W-1:0] CALC_LAST = DIDX_W'(CALC_CYCLES - 1);

  state_t              state_r, state_nxt;
  logic [DIDX_W-1:0]   calc_cnt_r, calc_cnt_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [DIG_W-1:0]    k_r, k_nxt;
  logic [RECT_CNT_W-1:0] rect_cnt_r, rect_cnt_nxt;

  logic final_digit;
  logic row_last;
  logic cap_hit;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CALC;
      calc_cnt_r <= '0;
      row_r      <= '0;
      k_r        <= '0;
      rect_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      calc_cnt_r <= calc_cnt_nxt;
      row_r      <= row_nxt;
      k_r        <= k_nxt;
      rect_cnt_r <= rect_cnt_nxt;
    end
  end

  // input taken only while idle
  assign in_ready = (state_r == S_IDLE);

  // end-of-transaction conditions
  assign final_digit = st.num_zero || (k_r == DIG_W'(MAX_DIGITS - 1));
  assign row_last    = (row_r == st.glyph_cnt - 3'd1);
  assign cap_hit     = (rect_cnt_r == RECT_CNT_W'(RECT_LIMIT - 1));

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    calc_cnt_nxt   = calc_cnt_r;
    row_nxt        = row_r;
    k_nxt          = k_r;
    rect_cnt_nxt   = rect_cnt_r;
    cmd            = '0;
    cmd.row        = row_r;
    cmd.calc_idx   = calc_cnt_r;

    unique case (state_r)
      S_CALC: begin
        cmd.calc_valid = (calc_cnt_r < DIDX_W'(NUM_DIST));
        calc_cnt_nxt   = calc_cnt_r + 3'd1;
        if (calc_cnt_r == CALC_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          cmd.load     = 1'b1;
          k_nxt        = '0;
          rect_cnt_nxt = '0;
          state_nxt    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.extract = 1'b1;
        row_nxt     = '0;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.last     = (row_last && final_digit) || cap_hit;
          row_nxt      = row_r + 3'd1;
          rect_cnt_nxt = rect_cnt_r + 5'd1;
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else if (row_last) begin
            cmd.next_digit = 1'b1;
            k_nxt          = k_r + DIG_W'(1);
            state_nxt      = S_DIGIT;
          end
        end
      end
      default: state_nxt = S_CALC;
    endcase

    // a new height invalidates the distance table
    if (cfg_wr_en) begin
      state_nxt    = S_CALC;
      calc_cnt_nxt = '0;
    end
  end

endmodule

// ===== rtl/sdrg_datapath.sv =====
// Datapath of the score digit rectangle generator: height register, distance
// table, digit extraction and the result register. Depends on sdrg_pkg.
module sdrg_datapath
  import sdrg_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic [NUMBER_W-1:0]    in_number,
  input  logic [AX_W-1:0]        in_anchor_x,
  input  logic [AY_W-1:0]        in_anchor_y,
  input  dp_cmd_t                cmd,
  output dp_status_t             st,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [RX_W-1:0]        out_rect_x,
  output logic [RY_W-1:0]        out_rect_y,
  output logic [RW_W-1:0]        out_rect_w,
  output logic [RH_W-1:0]        out_rect_h,
  output logic                   out_last
);

  localparam int KF_W   = KSCALE_W + FRAC_BITS;
  localparam int V_W    = CFG_W + KF_W;
  localparam int U_W    = V_W - 4;
  localparam int P_W    = U_W + 32;
  localparam int DIST_W = CFG_W + FRAC_BITS;
  localparam int QP_W   = NUMBER_W + 16;

  logic [CFG_W-1:0]  height_r;

  // distance calculation pipeline
  logic [V_W-1:0]    calc_v_r;
  logic              calc_v_vld_r;
  logic [DIDX_W-1:0] calc_v_idx_r;
  logic [U_W-1:0]    calc_u_r;
  logic [P_W-1:0]    calc_p_r;
  logic              calc_p_vld_r;
  logic [DIDX_W-1:0] calc_p_idx_r;
  logic [DIST_W-1:0] dist_r [NUM_DIST];

  logic [KF_W-1:0]   kf;
  logic [U_W-1:0]    q0;
  logic [U_W-1:0]    rem25;
  logic [U_W-1:0]    q_fix;

  // item registers
  logic [NUMBER_W-1:0] num_r;
  logic [AY_W-1:0]     ay_r;
  logic [RX_W-1:0]     left_r;
  logic [DIGIT_W-1:0]  digit_r;

  logic [QP_W-1:0]     qprod;
  logic [NUMBER_W-1:0] num_q;
  logic [NUMBER_W-1:0] num_rem;

  // result register
  logic            out_valid_r;
  logic [RX_W-1:0] rect_x_r;
  logic [RY_W-1:0] rect_y_r;
  logic [RW_W-1:0] rect_w_r;
  logic [RH_W-1:0] rect_h_r;
  logic            last_r;

  // bar geometry
  logic [5:0]        pair;
  logic [2:0]        pa, pb;
  logic [DIST_W-1:0] ya, yb, yl, yd, xl, xd;

  // height register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      height_r <= cfg_wr_data;
    end
  end

  // stage 1: h * (k << F); stage 2: times reciprocal of 25; stage 3: correct
  assign kf    = KF_W'(dist_k(cmd.calc_idx)) << FRAC_BITS;
  assign q0    = U_W'(calc_p_r >> 32);
  assign rem25 = calc_u_r - ((q0 << 4) + (q0 << 3) + q0);
  assign q_fix = (rem25 >= U_W'(25)) ? q0 + U_W'(1) : q0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_v_vld_r <= 1'b0;
      calc_p_vld_r <= 1'b0;
    end else begin
      calc_v_vld_r <= cmd.calc_valid;
      calc_p_vld_r <= calc_v_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    calc_v_r     <= V_W'(height_r) * V_W'(kf);
    calc_v_idx_r <= cmd.calc_idx;
    calc_u_r     <= U_W'(calc_v_r >> 4);
    calc_p_r     <= P_W'(U_W'(calc_v_r >> 4)) * P_W'(RECIP_25);
    calc_p_idx_r <= calc_v_idx_r;
    if (calc_p_vld_r) begin
      dist_r[calc_p_idx_r] <= DIST_W'(q_fix);
    end
  end

  // divide by ten for digit extraction
  assign qprod   = QP_W'(num_r) * QP_W'(RECIP_10);
  assign num_q   = NUMBER_W'(qprod >> 19);
  assign num_rem = num_r - ((num_q << 3) + (num_q << 1));

  // item load, digit step and advance
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r  <= in_number;
      ay_r   <= in_anchor_y;
      left_r <= RX_W'(in_anchor_x) - RX_W'(dist_r[DIST_ADV]);
    end else begin
      if (cmd.extract) begin
        num_r   <= num_q;
        digit_r <= DIGIT_W'(num_rem);
      end
      if (cmd.next_digit) begin
        left_r <= left_r - (RX_W'(dist_r[DIST_ADV]) << 1);
      end
    end
  end

  // corner and extents of the current bar
  assign pair = glyph_pair(digit_r, cmd.row);
  assign pa   = pair[5:3];
  assign pb   = pair[2:0];

  always_comb begin
    unique case (pa[1:0])
      2'd1:    ya = dist_r[DIST_MID];
      2'd2:    ya = dist_r[DIST_BOTTOM];
      default: ya = '0;
    endcase
    unique case (pb[1:0])
      2'd1:    yb = dist_r[DIST_MID];
      2'd2:    yb = dist_r[DIST_BOTTOM];
      default: yb = '0;
    endcase
    if (ya < yb) begin
      yl = ya;
      yd = yb - ya;
    end else begin
      yl = yb;
      yd = ya - yb;
    end
    xl = (pa[2] && pb[2]) ? dist_r[DIST_WIDTH] : '0;
    xd = (pa[2] ^ pb[2]) ? dist_r[DIST_WIDTH] : '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rect_x_r <= left_r + RX_W'(xl);
      rect_y_r <= RY_W'(ay_r) + RY_W'(yl);
      rect_w_r <= RW_W'(dist_r[DIST_BAR]) + RW_W'(xd);
      rect_h_r <= RH_W'(dist_r[DIST_BAR]) + RH_W'(yd);
      last_r   <= cmd.last;
    end
  end

  assign st.num_zero  = (num_r == '0);
  assign st.glyph_cnt = glyph_count(digit_r);
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_rect_x = rect_x_r;
  assign out_rect_y = rect_y_r;
  assign out_rect_w = rect_w_r;
  assign out_rect_h = rect_h_r;
  assign out_last   = last_r;

endmodule

// ===== dv/score_digit_rect_generator_core_test.sv =====
// Self-checking testbench for score_digit_rect_generator_core: a directed table, then
// random numbers and anchors over several digit heights, each bar rectangle checked.
// Depends on sdrg_pkg and the core RTL only.
`timescale 1ns / 1ps

module score_digit_rect_generator_core_test;
  import sdrg_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 8;
  localparam int MAX_GAP      = 18;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS  = 49;
  localparam int HOLD_AT      = 1500;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = 40;
  localparam int NUMBER_MAX   = (1 << NUMBER_W) - 1;

  // glyph corner codes: bit 2 selects the right column, bits 1..0 the row
  typedef enum bit [2:0] {
    TL = 3'd0, ML = 3'd1, BL = 3'd2, TR = 3'd4, MR = 3'd5, BR = 3'd6
  } corner_e;
  localparam bit [1:0] ROW_MID = 2'd1;
  localparam bit [1:0] ROW_BOT = 2'd2;

  // distance scale factors, out of 400 per digit height
  localparam int unsigned K_BAR   = 60;
  localparam int unsigned K_WIDE  = 160;
  localparam int unsigned K_MID   = 153;
  localparam int unsigned K_BOT   = 340;
  localparam int unsigned K_ADV   = 220;

  localparam bit [CFG_W-1:0] HEIGHT_MAX  = '1;
  localparam bit [CFG_W-1:0] HEIGHT_MIN  = 10'd1;
  localparam bit [CFG_W-1:0] HEIGHT_ZERO = '0;

  typedef struct packed {
    logic signed [RX_W-1:0] x;
    logic [RY_W-1:0]        y;
    logic [RW_W-1:0]        w;
    logic [RH_W-1:0]        h;
    logic                   last;
  } bar_rect_t;

  // bars listed first-to-last from the top of the word, two corners each
  typedef struct packed {
    bit [2:0]  count;
    bit [29:0] bars;
  } glyph_t;

  typedef enum bit {STEP_ITEM, STEP_HEIGHT} step_kind_e;

  // directed row: for a height step the value travels in number
  typedef struct packed {
    step_kind_e              kind;
    bit [NUMBER_W-1:0]       number;
    bit [AX_W-1:0]           ax;
    bit [AY_W-1:0]           ay;
    bit                      typed;
    bit signed [RX_W-1:0]    tx;
    bit [RY_W-1:0]           ty;
    bit [RW_W-1:0]           tw;
    bit [RH_W-1:0]           th;
  } step_t;

  localparam int SCRIPT_LEN = 21;
  step_t script [0:SCRIPT_LEN-1] = '{
    // reset height: a single "1", zero, every digit, widest values, dropped digits
    '{STEP_ITEM,   17'd1,      15'd1000,  15'd100,   1'b1, 18'sd923, 16'd100, 14'd76, 14'd511},
    '{STEP_ITEM,   17'd0,      15'd500,   15'd50,    1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd12345,  15'd20000, 15'd300,   1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd67890,  15'd30000, 15'd1000,  1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd99999,  15'd32767, 15'd32767, 1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd131071, 15'd32767, 15'd0,     1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd100000, 15'd4000,  15'd2000,  1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd88888,  15'd0,     15'd0,     1'b0, '0, '0, '0, '0},
    // tallest digits, left edges below zero
    '{STEP_HEIGHT, 17'd1023,   '0, '0, 1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd1,      15'd0,     15'd32767, 1'b1, -18'sd2455, 16'd32767, 14'd2455,
      14'd16367},
    '{STEP_ITEM,   17'd8,      15'd32767, 15'd32767, 1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd99999,  15'd10000, 15'd500,   1'b0, '0, '0, '0, '0},
    // smallest non-zero height
    '{STEP_HEIGHT, 17'd1,      '0, '0, 1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd1,      15'd100,   15'd0,     1'b1, 18'sd98, 16'd0, 14'd2, 14'd15},
    '{STEP_ITEM,   17'd45,     15'd0,     15'd21845, 1'b0, '0, '0, '0, '0},
    // zero height: empty rectangles on the digit left edges
    '{STEP_HEIGHT, 17'd0,      '0, '0, 1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd1,      15'd5,     15'd7,     1'b1, 18'sd5, 16'd7, 14'd0, 14'd0},
    '{STEP_ITEM,   17'd2,      15'd1234,  15'd5678,  1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd131071, 15'd32767, 15'd32767, 1'b0, '0, '0, '0, '0},
    // back to the reset value
    '{STEP_HEIGHT, 17'd32,     '0, '0, 1'b0, '0, '0, '0, '0},
    '{STEP_ITEM,   17'd7,      15'd16384, 15'd16384, 1'b0, '0, '0, '0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // number, anchor_x, anchor_y, zero pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // rect_x, rect_y, rect_w, rect_h, zero pad
  logic                   out_tlast;

  bit [CFG_W-1:0] digit_height = HEIGHT_RESET;
  bar_rect_t      pending_rects[$];
  int unsigned    items_drawn;
  int unsigned    rects_seen;
  int unsigned    heights_set;
  int unsigned    mismatches;

  score_digit_rect_generator_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // one line per mismatch
  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    $display("MISMATCH rect %0d %s: expected %0d, got %0d", rects_seen, what, want, got);
  endtask

  // bars of each decimal glyph in drawing order
  function automatic glyph_t glyph_of(input int unsigned d);
    glyph_t g;
    case (d)
      0: g = '{3'd4, {TL, TR, TR, BR, BR, BL, TL, BL, 6'b0}};
      1: g = '{3'd1, {TR, BR, 24'b0}};
      2: g = '{3'd5, {TL, TR, TR, MR, MR, ML, ML, BL, BL, BR}};
      3: g = '{3'd4, {TR, BR, TL, TR, ML, MR, BL, BR, 6'b0}};
      4: g = '{3'd4, {TR, BR, TL, ML, TR, MR, MR, ML, 6'b0}};
      5: g = '{3'd5, {TL, TR, TL, ML, ML, MR, MR, BR, BL, BR}};
      6: g = '{3'd4, {TL, BL, ML, MR, MR, BR, BR, BL, 6'b0}};
      7: g = '{3'd2, {TR, BR, TL, TR, 18'b0}};
      8: g = '{3'd5, {TR, BR, TL, BL, TL, TR, BL, BR, ML, MR}};
      default: g = '{3'd4, {TR, BR, ML, MR, ML, TL, TL, TR, 6'b0}};
    endcase
    return g;
  endfunction

  // floor(height in sub-pixels * k / 400)
  function automatic bit [31:0] scaled(input int unsigned k);
    bit [31:0] sub;
    sub = 32'(digit_height) << DEF_FRAC_BITS;
    return (sub * k) / 400;
  endfunction

  // expected rectangles of one number, least significant digit first
  task automatic draw_number(input bit [NUMBER_W-1:0] number, input bit [AX_W-1:0] ax,
                             input bit [AY_W-1:0] ay);
    bit [31:0] bar, wide, mid, bot, adv, left, xa, xb, ya, yb, xl, xh, yl, yh, sum;
    bit [NUMBER_W-1:0] rest;
    bit [2:0] ca, cb;
    int unsigned k, r;
    glyph_t g;
    bar_rect_t rc;
    bar_rect_t drawn[$];
    bar = scaled(K_BAR);
    wide = scaled(K_WIDE);
    mid = scaled(K_MID);
    bot = scaled(K_BOT);
    adv = scaled(K_ADV);
    rest = number;
    k = 0;
    do begin
      g = glyph_of(rest % 10);
      left = 32'(ax) - (2 * k + 1) * adv;
      for (r = 0; r < g.count && drawn.size() < RECT_LIMIT; r++) begin
        ca = g.bars[29 - 6 * r -: 3];
        cb = g.bars[26 - 6 * r -: 3];
        xa = ca[2] ? wide : 0;
        xb = cb[2] ? wide : 0;
        ya = (ca[1:0] == ROW_MID) ? mid : (ca[1:0] == ROW_BOT) ? bot : 0;
        yb = (cb[1:0] == ROW_MID) ? mid : (cb[1:0] == ROW_BOT) ? bot : 0;
        xl = (xa < xb) ? xa : xb;
        xh = (xa < xb) ? xb : xa;
        yl = (ya < yb) ? ya : yb;
        yh = (ya < yb) ? yb : ya;
        sum = left + xl;
        rc.x = sum[RX_W-1:0];
        sum = 32'(ay) + yl;
        rc.y = sum[RY_W-1:0];
        sum = bar + (xh - xl);
        rc.w = sum[RW_W-1:0];
        sum = bar + (yh - yl);
        rc.h = sum[RH_W-1:0];
        rc.last = 1'b0;
        drawn.push_back(rc);
      end
      rest = rest / 10;
      k++;
    end while (rest != 0 && k < DEF_MAX_DIGITS);
    drawn[drawn.size() - 1].last = 1'b1;
    foreach (drawn[i]) pending_rects.push_back(drawn[i]);
  endtask

  // offer one number after a random gap; predict once it is taken
  task automatic send_number(input bit [NUMBER_W-1:0] number, input bit [AX_W-1:0] ax,
                             input bit [AY_W-1:0] ay, input bit typed,
                             input bar_rect_t typed_rect);
    int unsigned gap;
    bit steady;
    steady = (items_drawn % 32) < 8;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, ay, ax, number};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (typed) pending_rects.push_back(typed_rect);
    else draw_number(number, ax, ay);
    items_drawn++;
  endtask

  // new height only once every outstanding rectangle is back
  task automatic set_height(input bit [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    digit_height = value;
    heights_set++;
  endtask

  function automatic bit [NUMBER_W-1:0] pick_number();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return NUMBER_W'($urandom_range(0, NUMBER_MAX));
    if (sel < 7) return NUMBER_W'($urandom_range(0, 999));
    if (sel < 8) return NUMBER_W'($urandom_range(0, 9));
    return NUMBER_W'($urandom_range(99990, NUMBER_MAX));
  endfunction

  // result side: random stalls, one long hold-off, field by field compare
  task automatic collect_rects();
    int unsigned pause;
    bit steady;
    bar_rect_t got;
    bar_rect_t want;
    steady = 1'b0;
    forever begin
      if (rects_seen % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      pause = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (rects_seen == HOLD_AT) pause = HOLD_CYCLES;
      if (pause != 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.x    = out_tdata[RX_W-1:0];
      got.y    = out_tdata[RX_W +: RY_W];
      got.w    = out_tdata[RX_W+RY_W +: RW_W];
      got.h    = out_tdata[RX_W+RY_W+RW_W +: RH_W];
      got.last = out_tlast;
      if (pending_rects.size() == 0) begin
        flag_mismatch("with nothing outstanding, rect_x", 0, got.x);
      end else begin
        want = pending_rects.pop_front();
        if (got.x != want.x) flag_mismatch("rect_x", want.x, got.x);
        if (got.y != want.y) flag_mismatch("rect_y", want.y, got.y);
        if (got.w != want.w) flag_mismatch("rect_w", want.w, got.w);
        if (got.h != want.h) flag_mismatch("rect_h", want.h, got.h);
        if (got.last != want.last) flag_mismatch("last_rect", want.last, got.last);
      end
      rects_seen++;
    end
  endtask

  // stimulus: directed table, then random phases over several heights
  initial begin
    step_t st;
    bar_rect_t typed_rect;
    bit [CFG_W-1:0] ht;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    fork
      collect_rects();
    join_none

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      st = script[i];
      if (st.kind == STEP_HEIGHT) begin
        set_height(st.number[CFG_W-1:0]);
      end else begin
        typed_rect = '{st.tx, st.ty, st.tw, st.th, 1'b1};
        send_number(st.number, st.ax, st.ay, st.typed, typed_rect);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1:       ht = HEIGHT_MAX;
        2:       ht = HEIGHT_MIN;
        4:       ht = HEIGHT_ZERO;
        5:       ht = CFG_W'($urandom_range(0, 1023));
        default: ht = CFG_W'($urandom_range(1, 1023));
      endcase
      set_height(ht);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_number(pick_number(), AX_W'($urandom), AY_W'($urandom), 1'b0, '0);
    end

    // drain and let the block settle
    in_tvalid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d numbers over %0d height writes, %0d bar rectangles compared",
             items_drawn, heights_set, rects_seen);
    $display("including a %0d-cycle result stall with input still offered", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d rectangles outstanding", pending_rects.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sdrg_pkg.sv
rtl/sdrg_ctrl.sv
rtl/sdrg_datapath.sv
rtl/score_digit_rect_generator_core.sv
dv/score_digit_rect_generator_core_test.sv
